// ----- src/mrtu_pkg.sv -----
package mrtu_pkg;

	localparam int unsigned LEN_W     = 9;
	localparam int unsigned HDR_DEPTH = 6;

	localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
	localparam logic [15:0]      CRC_POLY  = 16'hA001;
	localparam logic [LEN_W-1:0] LEN_MAX   = 9'd511;
	localparam logic [LEN_W-1:0] LEN_FLOOR = 9'd4;
	localparam logic [LEN_W-1:0] LEN_EXC   = 9'd5;
	localparam logic [LEN_W-1:0] LEN_REQ   = 9'd8;
	localparam logic [LEN_W-1:0] RESP_OVHD = 9'd5;

	localparam logic [LEN_W-1:0] MIN_LEN_RST = 9'd4;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 9'd256;

	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FC_EXC_MASK     = 8'h7F;

	// configuration register indexes
	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	typedef enum logic [1:0] {
		KIND_UNKNOWN   = 2'd0,
		KIND_REQUEST   = 2'd1,
		KIND_RESPONSE  = 2'd2,
		KIND_EXCEPTION = 2'd3
	} kind_t;

	// running frame state after the current byte has been folded in
	typedef struct packed {
		logic [15:0]                     crc;
		logic [LEN_W-1:0]                len;
		logic [HDR_DEPTH-1:0][7:0]       hdr;
	} frame_t;

	// packed so that frame_ok sits in bit 0
	typedef struct packed {
		logic [LEN_W-1:0] frame_length;
		logic [6:0]       response_registers;
		logic [7:0]       resp_byte_cnt;
		logic [15:0]      requested_count;
		logic [15:0]      start_address;
		logic [7:0]       exc_code;
		logic [7:0]       fn_code;
		logic [7:0]       slave_address;
		kind_t            frame_kind;
		logic             frame_ok;
	} result_t;

	// frame_ok and frame_kind travel on tuser, the rest on tdata
	localparam int unsigned TUSER_W = 3;
	localparam int unsigned RES_W   = $bits(result_t);
	localparam int unsigned TDATA_W = ((RES_W - TUSER_W + 7) / 8) * 8;

	// one byte of CRC-16/MODBUS, bit loop unrolled by synthesis
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- src/modbus_rtu_frame_parser_core.sv -----
// Modbus RTU frame parser. Frame bytes arrive one per beat on the slave
// stream in wire order, tlast on the final byte. Each byte is registered,
// then folded into a running CRC-16/MODBUS (0xA001
// reflected, init 0xFFFF), a length count saturating at 511 and a copy of
// the first six bytes. On the tlast byte one result beat is loaded into the
// output register: frame_ok is set when the length lies within
// [min_frame_len, max_frame_len], is at least 4, and the CRC residue over
// all bytes is zero; an accepted frame is then typed as exception, read
// request (8 bytes, FC 3 or 4), read response (even byte count equal to
// length minus 5) or unknown. frame_ok and the frame type ride on tuser,
// the decoded fields on tdata. Rejected frames report only frame_length.
// Throughput is one byte per cycle; the input takes a byte each cycle even
// while a result waits, and stalls only when a second frame end reaches the
// CRC stage before the pending result has been taken. The tlast byte passes
// through the input register stage, then the result beat is loaded into the
// output register, from which it is presented. Limits are written through
// cfg_we/cfg_addr/cfg_data (index 0 minimum, index 1 maximum) and must only
// change while no frame is in flight.
module modbus_rtu_frame_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [mrtu_pkg::LEN_W-1:0]    cfg_data,
	// byte stream in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
	input  logic                          s_axis_tlast,   // end_of_frame
	// result stream out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] frame_ok, [2:1] frame_kind
	output logic [mrtu_pkg::TUSER_W-1:0]  m_axis_tuser,
	// [7:0] slave_address, [15:8] fn_code, [23:16] exc_code,
	// [39:24] start_address, [55:40] requested_count, [63:56] resp_byte_cnt,
	// [70:64] response_registers, [79:71] frame_length
	output logic [mrtu_pkg::TDATA_W-1:0]  m_axis_tdata
);
	import mrtu_pkg::*;

	// limit registers
	logic [LEN_W-1:0] min_len_q;
	logic [LEN_W-1:0] max_len_q;

	// input register stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// result register
	logic             res_valid_q;
	result_t          res_q;

	logic             adv;
	frame_t           frm_nxt;
	result_t          res_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_LEN: min_len_q <= cfg_data;
				REG_MAX_LEN: max_len_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// A byte leaves stage 1 unless it ends a frame and the result register
	// is still occupied by a beat nobody has taken.
	assign adv = valid_s1 && (!last_s1 || !res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// CRC, length and header capture
	mrtu_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.data_byte (byte_s1),
		.last      (last_s1),
		.frm_nxt   (frm_nxt)
	);

	// accept/reject and frame typing on the completed frame
	mrtu_classify u_classify (
		.frm     (frm_nxt),
		.min_len (min_len_q),
		.max_len (max_len_q),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tuser  = {res_q.frame_kind, res_q.frame_ok};
	assign m_axis_tdata  = TDATA_W'(res_q[RES_W-1:TUSER_W]);

`ifndef SYNTH
	// input only stalls behind a pending result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> res_valid_q)
		else $error("input stalled with no result pending");

	// an accepted frame is never shorter than four bytes
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.frame_ok |-> res_q.frame_length >= LEN_FLOOR)
		else $error("accepted frame shorter than the floor");

	// a rejected frame carries nothing but its length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.frame_ok |->
			res_q[RES_W-LEN_W-1:0] == '0)
		else $error("rejected frame has non-zero fields");

	// response register count is half the byte count
	a_resp_regs: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.frame_kind == KIND_RESPONSE |->
			{res_q.response_registers, 1'b0} == res_q.resp_byte_cnt)
		else $error("response register count mismatch");
`endif

endmodule

// ----- src/mrtu_accum.sv -----
module mrtu_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          data_byte,
	input  logic                last,
	output mrtu_pkg::frame_t    frm_nxt
);
	import mrtu_pkg::*;

	logic [15:0]               crc_q;
	logic [LEN_W-1:0]          len_q;
	logic [HDR_DEPTH-1:0][7:0] hdr_q;

	always_comb begin
		frm_nxt.crc = crc_byte(crc_q, data_byte);
		frm_nxt.len = (len_q < LEN_MAX) ? len_q + 9'd1 : len_q;
		for (int i = 0; i < HDR_DEPTH; i++) begin
			frm_nxt.hdr[i] = (len_q == LEN_W'(i)) ? data_byte : hdr_q[i];
		end
	end

	// end of frame returns everything to the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			len_q <= '0;
			hdr_q <= '0;
		end else if (adv) begin
			if (last) begin
				crc_q <= CRC_INIT;
				len_q <= '0;
				hdr_q <= '0;
			end else begin
				crc_q <= frm_nxt.crc;
				len_q <= frm_nxt.len;
				hdr_q <= frm_nxt.hdr;
			end
		end
	end

endmodule

// ----- src/mrtu_classify.sv -----
module mrtu_classify (
	input  mrtu_pkg::frame_t          frm,
	input  logic [mrtu_pkg::LEN_W-1:0] min_len,
	input  logic [mrtu_pkg::LEN_W-1:0] max_len,
	output mrtu_pkg::result_t         res
);
	import mrtu_pkg::*;

	logic       ok;
	logic [7:0] fc;
	logic       fc_read;
	logic       len_ge5;

	assign ok = (frm.len >= LEN_FLOOR) && (frm.len >= min_len) &&
		(frm.len <= max_len) && (frm.crc == 16'h0000);
	assign fc      = frm.hdr[1];
	assign fc_read = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
	assign len_ge5 = frm.len >= LEN_EXC;

	always_comb begin
		res = '0;
		res.frame_length = frm.len;
		if (ok) begin
			res.frame_ok      = 1'b1;
			res.slave_address = frm.hdr[0];
			res.fn_code       = fc;
			priority if (fc[7]) begin
				res.frame_kind = KIND_EXCEPTION;
				res.fn_code    = fc & FC_EXC_MASK;
				res.exc_code   = len_ge5 ? frm.hdr[2] : 8'h00;
			end else if (fc_read && frm.len == LEN_REQ) begin
				res.frame_kind      = KIND_REQUEST;
				res.start_address   = {frm.hdr[2], frm.hdr[3]};
				res.requested_count = {frm.hdr[4], frm.hdr[5]};
			end else if (fc_read && len_ge5 && !frm.hdr[2][0] &&
					({1'b0, frm.hdr[2]} + RESP_OVHD == frm.len)) begin
				res.frame_kind         = KIND_RESPONSE;
				res.resp_byte_cnt      = frm.hdr[2];
				res.response_registers = frm.hdr[2][7:1];
			end else begin
				res.frame_kind = KIND_UNKNOWN;
			end
		end
	end

endmodule
